// ===== rtl/core/iwd_pkg.sv =====
// Package for the instruction word decoder: mnemonic codes, field widths
// and the decoded result record. No dependencies.

package iwd_pkg;

    typedef logic [5:0] mn_t;

    localparam mn_t MN_REG_LAST   = 6'd25;
    localparam mn_t MN_IMM_BASE   = 6'd26;
    localparam mn_t MN_LOAD_BASE  = 6'd34;
    localparam mn_t MN_STORE_BASE = 6'd39;
    localparam mn_t MN_BR_BASE    = 6'd42;
    localparam mn_t MN_J          = 6'd48;
    localparam mn_t MN_JAL        = 6'd49;
    localparam mn_t MN_JR         = 6'd50;
    localparam mn_t MN_JALR       = 6'd51;
    localparam mn_t MN_LUI        = 6'd52;
    localparam mn_t MN_MFSR       = 6'd53;
    localparam mn_t MN_MTSR       = 6'd54;
    localparam mn_t MN_RFE        = 6'd55;
    localparam mn_t MN_HALT       = 6'd56;
    localparam mn_t MN_BREAK      = 6'd57;
    localparam mn_t MN_SYSCALL    = 6'd58;
    localparam mn_t MN_TLBFLUSH   = 6'd59;
    localparam mn_t MN_CAS        = 6'd60;
    localparam mn_t MN_INVALID    = 6'd61;

    typedef enum logic [5:0] {
        OP_REG      = 6'd0,
        OP_IMM      = 6'd1,
        OP_LOAD     = 6'd2,
        OP_STORE    = 6'd3,
        OP_BRANCH   = 6'd4,
        OP_J        = 6'd5,
        OP_JAL      = 6'd6,
        OP_JREG     = 6'd7,
        OP_LUI      = 6'd8,
        OP_SYS      = 6'd9,
        OP_SYSCALL  = 6'd10,
        OP_TLBFLUSH = 6'd11,
        OP_CAS      = 6'd12
    } opcode_t;

    typedef enum logic [3:0] {
        SO_MFSR  = 4'd0,
        SO_MTSR  = 4'd1,
        SO_RFE   = 4'd2,
        SO_HALT  = 4'd3,
        SO_BREAK = 4'd4
    } sys_op_t;

    localparam int unsigned IMM_W      = 26;
    localparam logic [4:0]  SYS_REG_NUM = 5'd12;
    localparam logic [4:0]  REG_SUB_NUM = 5'd26;

    typedef struct packed {
        mn_t              mnemonic;
        logic             known;
        logic [3:0]       first_reg;
        logic [3:0]       second_reg;
        logic [3:0]       third_reg;
        logic [3:0]       sys_reg;
        logic [IMM_W-1:0] immediate;
        logic [31:0]      target;
    } iwd_result_t;

endpackage

// ===== rtl/core/iwd_decode.sv =====
// Field decode and target adder for one instruction word.
// Depends on iwd_pkg.

module iwd_decode (
    input  logic                 [31:0] word,
    input  logic                 [31:0] address,
    output iwd_pkg::iwd_result_t        result
);
    import iwd_pkg::*;

    always_comb
    begin
        logic [5:0]  op;
        mn_t         mn;
        logic [3:0]  r1;
        logic [3:0]  r2;
        logic [3:0]  r3;
        logic [3:0]  sr;
        logic [25:0] imm;
        logic [29:0] off;
        logic        has_tgt;
        logic [31:0] tgt;

        op      = word[31:26];
        mn      = MN_INVALID;
        r1      = '0;
        r2      = '0;
        r3      = '0;
        sr      = '0;
        imm     = '0;
        off     = '0;
        has_tgt = 1'b0;

        unique case (op) inside
            OP_REG:
            begin
                if (word[5:0] == 6'd0 && word[10:6] < REG_SUB_NUM)
                begin
                    mn = {1'b0, word[10:6]};
                    r1 = word[24:21];
                    r2 = word[19:16];
                    r3 = word[14:11];
                end
            end
            OP_IMM:
            begin
                if (!word[15])
                begin
                    mn  = MN_IMM_BASE + {3'b000, word[14:12]};
                    r1  = word[24:21];
                    r2  = word[19:16];
                    imm = {14'd0, word[11:0]};
                end
            end
            OP_LOAD, OP_STORE:
            begin
                if (op == OP_LOAD ? (word[15:13] < 3'd5) : (word[15:13] < 3'd3))
                begin
                    mn  = (op == OP_LOAD ? MN_LOAD_BASE : MN_STORE_BASE)
                          + {3'b000, word[15:13]};
                    r1  = word[24:21];
                    r2  = word[19:16];
                    imm = {13'd0, word[12:0]};
                end
            end
            OP_BRANCH:
            begin
                if (word[25:23] < 3'd6)
                begin
                    mn      = MN_BR_BASE + {3'b000, word[25:23]};
                    r1      = word[21:18];
                    r2      = word[16:13];
                    imm     = {13'd0, word[12:0]};
                    off     = {{17{word[12]}}, word[12:0]};
                    has_tgt = 1'b1;
                end
            end
            OP_J, OP_JAL:
            begin
                mn      = (op == OP_J) ? MN_J : MN_JAL;
                imm     = word[25:0];
                off     = {{4{word[25]}}, word[25:0]};
                has_tgt = 1'b1;
            end
            OP_JREG:
            begin
                if (word[19:0] == 20'd0)
                begin
                    mn = word[25] ? MN_JALR : MN_JR;
                    r1 = word[23:20];
                end
            end
            OP_LUI:
            begin
                if (!word[0])
                begin
                    mn  = MN_LUI;
                    r1  = word[24:21];
                    imm = {6'd0, word[20:1]};
                end
            end
            OP_SYS:
            begin
                if (word[10:0] == 11'd0)
                begin
                    unique case (word[25:22]) inside
                        SO_MFSR, SO_MTSR:
                        begin
                            if (word[15:11] < SYS_REG_NUM)
                            begin
                                mn = (word[25:22] == SO_MFSR) ? MN_MFSR : MN_MTSR;
                                r1 = word[20:17];
                                sr = word[14:11];
                            end
                        end
                        SO_RFE:   mn = MN_RFE;
                        SO_HALT:  mn = MN_HALT;
                        SO_BREAK: mn = MN_BREAK;
                        default:  mn = MN_INVALID;
                    endcase
                end
            end
            OP_SYSCALL:
            begin
                mn  = MN_SYSCALL;
                imm = word[25:0];
            end
            OP_TLBFLUSH:
            begin
                if (word[19:0] == 20'd0)
                begin
                    mn = MN_TLBFLUSH;
                end
            end
            OP_CAS:
            begin
                if (word[10:0] == 11'd0)
                begin
                    mn = MN_CAS;
                    r1 = word[24:21];
                    r2 = word[19:16];
                    r3 = word[14:11];
                end
            end
            default:
            begin
                mn = MN_INVALID;
            end
        endcase

        tgt = has_tgt ? (address + 32'd4 + {off, 2'b00}) : 32'd0;

        result.mnemonic   = mn;
        result.known      = (mn != MN_INVALID);
        result.first_reg  = r1;
        result.second_reg = r2;
        result.third_reg  = r3;
        result.sys_reg    = sr;
        result.immediate  = imm;
        result.target     = tgt;
    end

endmodule

// ===== rtl/core/instruction_word_decoder_core.sv =====
// Instruction word decoder top level: input stage, decode, result stage.
// Depends on iwd_pkg and iwd_decode.
//
// Usage:
//   Slave stream s_*: one transfer carries an instruction word and its
//   byte address. Master stream m_*: one transfer carries the decoded
//   fields; m_tuser is the known flag (0 for an unrecognized word, then
//   mnemonic is the invalid code and every other field is zero).
//   Pipeline: two register stages (input register, result register)
//   with the decode and target adder between them.
//   Throughput: one transfer per cycle while m_tready is high, set by
//   the single decode stage.
//   Stall: while m_tready is low the result stage holds; the input stage
//   still takes one more word if empty, then s_tready drops until the
//   result is taken. Nothing is lost or repeated.
//   Reset: rst_n low empties both stages; the data registers are not reset.

module instruction_word_decoder_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // instr_word[31:0], instr_address[63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // mnemonic[5:0], first_reg[9:6], second_reg[13:10],
                                   // third_reg[17:14], sys_reg[21:18],
                                   // immediate[47:22], target[79:48]
    output logic        m_tuser    // known[0]
);
    import iwd_pkg::*;

    logic        s1_valid_reg;
    logic [31:0] s1_word_reg;
    logic [31:0] s1_addr_reg;
    logic        s2_valid_reg;
    iwd_result_t s2_res_reg;
    iwd_result_t dec_res;
    logic        s1_load;
    logic        s2_load;

    assign s2_load  = !s2_valid_reg || m_tready;
    assign s1_load  = !s1_valid_reg || s2_load;
    assign s_tready = s1_load;

    iwd_decode u_decode (
        .word    (s1_word_reg),
        .address (s1_addr_reg),
        .result  (dec_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg <= s_tvalid;
            end
            if (s2_load)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load && s_tvalid)
        begin
            s1_word_reg <= s_tdata[31:0];
            s1_addr_reg <= s_tdata[63:32];
        end
        if (s2_load && s1_valid_reg)
        begin
            s2_res_reg <= dec_res;
        end
    end

    assign m_tvalid = s2_valid_reg;
    assign m_tuser  = s2_res_reg.known;
    assign m_tdata  = {s2_res_reg.target,
                       s2_res_reg.immediate,
                       s2_res_reg.sys_reg,
                       s2_res_reg.third_reg,
                       s2_res_reg.second_reg,
                       s2_res_reg.first_reg,
                       s2_res_reg.mnemonic};

`ifndef NO_ASSERTIONS
    a_invalid_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |->
        (m_tdata[5:0] == MN_INVALID && m_tdata[79:6] == '0))
        else $error("unrecognized word with nonzero fields");

    a_known_code: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[5:0] < MN_INVALID))
        else $error("known result with out-of-range mnemonic");

    a_sysreg_use: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[21:18] != 4'd0) |->
        (m_tdata[5:0] == MN_MFSR || m_tdata[5:0] == MN_MTSR))
        else $error("system register set on a non-mfsr/mtsr result");

    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_load) |=> m_tvalid)
        else $error("decoded word lost between stages");
`endif

endmodule

// ===== sim/iwd_checker.sv =====
// Checker for instruction_word_decoder_core: watches both stream channels,
// predicts each decoded result and compares it field by field.
// Depends on iwd_pkg.

module iwd_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [79:0] m_tdata,
    input  logic        m_tuser,
    output int          err_count,
    output int          pending
);
    import iwd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] word;
        iwd_result_t res;
    } decode_entry_t;

    decode_entry_t expected_decodes[$];
    int            err_total = 0;

    assign err_count = err_total;

    function automatic iwd_result_t decode_word(logic [31:0] w, logic [31:0] pc);
        iwd_result_t r;
        logic [3:0]  so;
        logic [4:0]  sysn;
        r = '0;
        r.mnemonic = MN_INVALID;
        so = w[25:22];
        sysn = w[15:11];
        case (w[31:26]) inside
            OP_REG:
                if (w[5:0] == 6'd0 && w[10:6] < REG_SUB_NUM)
                begin
                    r.mnemonic = mn_t'(w[10:6]);
                    r.first_reg = w[24:21];
                    r.second_reg = w[19:16];
                    r.third_reg = w[14:11];
                end
            OP_IMM:
                if (w[15:12] < 4'd8)
                begin
                    r.mnemonic = MN_IMM_BASE + mn_t'(w[15:12]);
                    r.first_reg = w[24:21];
                    r.second_reg = w[19:16];
                    r.immediate = IMM_W'(w[11:0]);
                end
            OP_LOAD, OP_STORE:
                if ((w[31:26] == OP_LOAD && w[15:13] < 3'd5)
                        || (w[31:26] == OP_STORE && w[15:13] < 3'd3))
                begin
                    r.mnemonic = (w[31:26] == OP_LOAD ? MN_LOAD_BASE : MN_STORE_BASE)
                                 + mn_t'(w[15:13]);
                    r.first_reg = w[24:21];
                    r.second_reg = w[19:16];
                    r.immediate = IMM_W'(w[12:0]);
                end
            OP_BRANCH:
                if (w[25:23] < 3'd6)
                begin
                    r.mnemonic = MN_BR_BASE + mn_t'(w[25:23]);
                    r.first_reg = w[21:18];
                    r.second_reg = w[16:13];
                    r.immediate = IMM_W'(w[12:0]);
                    r.target = pc + 32'd4 + {{17{w[12]}}, w[12:0], 2'b00};
                end
            OP_J, OP_JAL:
            begin
                r.mnemonic = (w[31:26] == OP_J) ? MN_J : MN_JAL;
                r.immediate = w[25:0];
                r.target = pc + 32'd4 + {{4{w[25]}}, w[25:0], 2'b00};
            end
            OP_JREG:
                if (w[19:0] == 20'd0)
                begin
                    r.mnemonic = w[25] ? MN_JALR : MN_JR;
                    r.first_reg = w[23:20];
                end
            OP_LUI:
                if (!w[0])
                begin
                    r.mnemonic = MN_LUI;
                    r.first_reg = w[24:21];
                    r.immediate = IMM_W'(w[20:1]);
                end
            OP_SYS:
                if (w[10:0] == 11'd0)
                begin
                    if (so == SO_MFSR || so == SO_MTSR)
                    begin
                        if (sysn < SYS_REG_NUM)
                        begin
                            r.mnemonic = (so == SO_MFSR) ? MN_MFSR : MN_MTSR;
                            r.first_reg = w[20:17];
                            r.sys_reg = sysn[3:0];
                        end
                    end
                    else if (so == SO_RFE)
                    begin
                        r.mnemonic = MN_RFE;
                    end
                    else if (so == SO_HALT)
                    begin
                        r.mnemonic = MN_HALT;
                    end
                    else if (so == SO_BREAK)
                    begin
                        r.mnemonic = MN_BREAK;
                    end
                end
            OP_SYSCALL:
            begin
                r.mnemonic = MN_SYSCALL;
                r.immediate = w[25:0];
            end
            OP_TLBFLUSH:
                if (w[19:0] == 20'd0)
                    r.mnemonic = MN_TLBFLUSH;
            OP_CAS:
                if (w[10:0] == 11'd0)
                begin
                    r.mnemonic = MN_CAS;
                    r.first_reg = w[24:21];
                    r.second_reg = w[19:16];
                    r.third_reg = w[14:11];
                end
            default: ;
        endcase
        r.known = (r.mnemonic != MN_INVALID);
        return r;
    endfunction

    task automatic report(input string msg);
        $display("%0t ns mismatch: %s", $realtime, msg);
        err_total++;
    endtask

    task automatic check_field(input string name, input logic [31:0] word,
                               input logic [31:0] got, input logic [31:0] want);
        if (got !== want)
            report($sformatf("word %h %s got %0h want %0h", word, name, got, want));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        decode_entry_t e;
        if (!rst_n)
        begin
            expected_decodes.delete();
            pending <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_decodes.size() == 0)
                begin
                    report($sformatf("result transfer with no word pending, data %h",
                                     m_tdata));
                end
                else
                begin
                    e = expected_decodes.pop_front();
                    check_field("mnemonic", e.word, 32'(m_tdata[5:0]), 32'(e.res.mnemonic));
                    check_field("known", e.word, 32'(m_tuser), 32'(e.res.known));
                    check_field("first_reg", e.word, 32'(m_tdata[9:6]),
                                32'(e.res.first_reg));
                    check_field("second_reg", e.word, 32'(m_tdata[13:10]),
                                32'(e.res.second_reg));
                    check_field("third_reg", e.word, 32'(m_tdata[17:14]),
                                32'(e.res.third_reg));
                    check_field("sys_reg", e.word, 32'(m_tdata[21:18]),
                                32'(e.res.sys_reg));
                    check_field("immediate", e.word, 32'(m_tdata[47:22]),
                                32'(e.res.immediate));
                    check_field("target", e.word, m_tdata[79:48], e.res.target);
                end
            end
            if (s_tvalid && s_tready)
            begin
                e.word = s_tdata[31:0];
                e.res = decode_word(s_tdata[31:0], s_tdata[63:32]);
                expected_decodes.push_back(e);
            end
            pending <= expected_decodes.size();
        end
    end

endmodule

// ===== sim/tb.sv =====
// Top-level testbench for instruction_word_decoder_core: drives instruction
// words with random gaps and output stalls, and gives the verdict.
// Depends on iwd_pkg, instruction_word_decoder_core and iwd_checker.

module tb;
    import iwd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 950;
    localparam int IDLE_LIMIT   = 2000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;    // instr_word[31:0], instr_address[63:32]
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;    // mnemonic[5:0], first_reg[9:6], second_reg[13:10],
                             // third_reg[17:14], sys_reg[21:18],
                             // immediate[47:22], target[79:48]
    logic        m_tuser;    // known[0]
    int          err_count;
    int          pending;
    int          idle_cycles = 0;
    bit          calm = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    instruction_word_decoder_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    iwd_checker u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .err_count (err_count),
        .pending   (pending)
    );

    function automatic int draw_wait();
        return calm ? 0 : $urandom_range(0, 17);
    endfunction

    // mostly well-formed words with random operands; some reserved-bit and
    // subcode violations, unknown opcodes and raw noise
    function automatic logic [31:0] random_word();
        logic [31:0] w;
        int          pick;
        bit          clean;
        w = $urandom;
        pick = $urandom_range(0, 99);
        clean = ($urandom_range(0, 7) != 0);
        if (pick < 6)
            return w;
        if (pick < 12)
            w[31:26] = 6'($urandom_range(13, 63));
        else
            w[31:26] = 6'($urandom_range(0, 12));
        if (clean)
        begin
            case (w[31:26]) inside
                OP_REG:
                begin
                    w[5:0] = 6'd0;
                    w[10:6] = 5'($urandom_range(0, 25));
                end
                OP_IMM:    w[15:12] = 4'($urandom_range(0, 7));
                OP_LOAD:   w[15:13] = 3'($urandom_range(0, 4));
                OP_STORE:  w[15:13] = 3'($urandom_range(0, 2));
                OP_BRANCH: w[25:23] = 3'($urandom_range(0, 5));
                OP_JREG, OP_TLBFLUSH: w[19:0] = 20'd0;
                OP_LUI:    w[0] = 1'b0;
                OP_SYS:
                begin
                    w[10:0] = 11'd0;
                    w[25:22] = 4'($urandom_range(0, 4));
                    w[15:11] = 5'($urandom_range(0, 11));
                end
                OP_CAS:    w[10:0] = 11'd0;
                default: ;
            endcase
        end
        return w;
    endfunction

    function automatic logic [31:0] random_addr();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 32'($urandom_range(0, 64));
        if (pick == 1)
            return 32'hFFFF_FFFF - 32'($urandom_range(0, 64));
        return $urandom;
    endfunction

    task automatic send_word(input logic [31:0] word, input logic [31:0] addr);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {addr, word};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // result side stalls
    initial
    begin
        int gap;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = draw_wait();
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT)
        begin
            $display("instruction_word_decoder_core regression: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word({OP_REG, 26'h0}, 32'h0);
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word({OP_REG, 5'h1F, 5'h1F, 5'h1F, 5'd25, 6'd0}, 32'h1234_5678);
        send_word({OP_REG, 15'h0, 5'd26, 6'd0}, 32'h0);
        send_word({OP_REG, 20'h0, 6'h01}, 32'h0);
        send_word({OP_IMM, 5'h1F, 5'h1F, 4'd7, 12'hFFF}, 32'h0);
        send_word({OP_IMM, 10'h0, 4'd8, 12'h0}, 32'h0);
        send_word({OP_LOAD, 10'h3FF, 3'd4, 13'h1FFF}, 32'h0);
        send_word({OP_LOAD, 10'h0, 3'd5, 13'h0}, 32'h0);
        send_word({OP_STORE, 10'h155, 3'd2, 13'h0AAA}, 32'h0);
        send_word({OP_STORE, 10'h0, 3'd3, 13'h0}, 32'h0);
        // branch and jump offsets at both extremes, targets wrapping
        send_word({OP_BRANCH, 3'd5, 10'h3FF, 13'h1000}, 32'h0);
        send_word({OP_BRANCH, 3'd0, 10'h0, 13'h0FFF}, 32'hFFFF_FFF0);
        send_word({OP_BRANCH, 3'd6, 23'h0}, 32'h0);
        send_word({OP_J, 26'h200_0000}, 32'h0);
        send_word({OP_JAL, 26'h1FF_FFFF}, 32'hFFFF_FFFC);
        send_word({OP_JREG, 1'b1, 1'b0, 4'hF, 20'h0}, 32'h0);
        send_word({OP_JREG, 6'h0, 20'h00001}, 32'h0);
        send_word({OP_LUI, 5'h1F, 20'hFFFFF, 1'b0}, 32'h0);
        send_word({OP_LUI, 25'h0, 1'b1}, 32'h0);
        send_word({OP_SYS, SO_MFSR, 1'b0, 4'hF, 1'b0, 5'd11, 11'h0}, 32'h0);
        send_word({OP_SYS, SO_MTSR, 1'b0, 4'h5, 1'b0, 5'd12, 11'h0}, 32'h0);
        send_word({OP_SYS, SO_BREAK + 4'd1, 22'h0}, 32'h0);
        send_word({OP_SYS, SO_RFE, 22'h0}, 32'h0);
        send_word({OP_SYS, SO_HALT, 22'h0}, 32'h0);
        send_word({OP_SYS, SO_BREAK, 22'h0}, 32'h0);
        send_word({OP_SYSCALL, 26'h3FF_FFFF}, 32'h0);
        send_word({OP_TLBFLUSH, 26'h0}, 32'h0);
        send_word({OP_CAS, 15'h7FFF, 11'h400}, 32'h0);
        send_word({OP_CAS, 15'h7FFF, 11'h0}, 32'h0);

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i % 50 == 0)
                calm = ($urandom_range(0, 3) == 0);
            send_word(random_word(), random_addr());
        end
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        if (err_count == 0)
            $display("instruction_word_decoder_core regression: pass");
        else
            $display("instruction_word_decoder_core regression: fail");
        $finish;
    end

endmodule
